[sv/subbyte_tile_transposer_defines.svh]
// Assertion macros shared by the transposer RTL.
`ifndef SUBBYTE_TILE_TRANSPOSER_DEFINES_SVH
`define SUBBYTE_TILE_TRANSPOSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("transposer check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define STT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("transposer check failed");

`endif

[sv/stt_pkg.sv]
// Shared types and constants of the subbyte tile transposer.
`default_nettype none

package stt_pkg;

    // Default tile edge in elements
    localparam int STT_TILE_ELEMS = 64;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_IDX_NIBBLE_MODE = 1'b0;

    // Nibble masks
    localparam logic [7:0] NIB_MASK = 8'h0F;
    localparam logic [7:0] NIB_HIGH = 8'hF0;

    // Request opcodes
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } stt_op_t;

    // Per-read control that travels with the bank read
    typedef struct packed {
        logic in_range;  // position lies inside the tile
        logic nibble;    // packed int4 interpretation
        logic bank_sel;  // int8: odd original row lives in bank 1
        logic odd_elem;  // int4: element column odd, take high nibbles
    } stt_rd_info_t;

    // Pipeline status seen by the top level
    typedef struct packed {
        logic s1_valid;  // bank read data register holds a request
        logic hold;      // stage 1 cannot move on this cycle
    } stt_status_t;

endpackage

`default_nettype wire

[sv/stt_cfg_regs.sv]
// APB-style configuration register block (nibble_mode).
`default_nettype none

module stt_cfg_regs
    import stt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic                    nibble_mode
);

    logic mode_reg;
    logic mode_next;
    logic wr_strobe;

    assign pready = 1'b1;
    assign wr_strobe = psel && penable && pwrite && pready;

    // Register write decode; paddr[2] selects the word
    always_comb
    begin
        mode_next = mode_reg;
        if (wr_strobe && (paddr[2] == REG_IDX_NIBBLE_MODE))
        begin
            mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // Read back; unmapped words read zero
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_IDX_NIBBLE_MODE)
        begin
            prdata = {{(PDATA_W-1){1'b0}}, mode_reg};
        end
    end

    assign nibble_mode = mode_reg;

endmodule

`default_nettype wire

[sv/stt_bank.sv]
// One row-parity bank of the tile store: 1 write port, 1 registered read port.
`default_nettype none

module stt_bank
    import stt_pkg::*;
#(
    parameter int DEPTH  = STT_TILE_ELEMS * STT_TILE_ELEMS / 2,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[sv/stt_out_stage.sv]
// Read pipeline control, nibble assembly and result register.
`default_nettype none

module stt_out_stage
    import stt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         rd_issue,
    input  wire stt_rd_info_t info_in,
    input  wire logic [7:0]   bank0_data,
    input  wire logic [7:0]   bank1_data,
    input  wire logic         out_stall,
    output logic              out_valid,
    output logic [7:0]        read_byte,
    output stt_status_t       status
);

    logic         s1_valid_reg;
    logic         s1_valid_next;
    stt_rd_info_t info_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [7:0]   out_byte_reg;
    logic [7:0]   out_byte_next;
    logic         advance;
    logic [3:0]   lo_nib;
    logic [3:0]   hi_nib;

    // Stage 1 moves on when the result register is free or being taken
    assign advance = !out_valid_reg || !out_stall;

    // Control next state
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
            s1_valid_next = 1'b0;
        end
        if (rd_issue)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Control word captured alongside the bank read
    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            info_reg <= info_in;
        end
    end

    // int4: low nibble from even row bank, high nibble from odd row bank
    assign lo_nib = info_reg.odd_elem ? bank0_data[7:4] : bank0_data[3:0];
    assign hi_nib = info_reg.odd_elem ? bank1_data[7:4] : bank1_data[3:0];

    always_comb
    begin
        out_byte_next = '0;
        if (info_reg.in_range)
        begin
            if (info_reg.nibble)
            begin
                out_byte_next = ({4'h0, lo_nib} & NIB_MASK) | ({hi_nib, 4'h0} & NIB_HIGH);
            end
            else
            begin
                out_byte_next = info_reg.bank_sel ? bank1_data : bank0_data;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_byte_reg <= out_byte_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_byte = out_byte_reg;
    assign status.s1_valid = s1_valid_reg;
    assign status.hold = s1_valid_reg && !advance;

endmodule

`default_nettype wire

[sv/subbyte_tile_transposer.sv]
// Top level of the subbyte tile transposer.
`default_nettype none
`include "subbyte_tile_transposer_defines.svh"

// Holds one TILE_ELEMS x TILE_ELEMS tile as bytes in two banks split by
// original row parity, so a packed int4 read fetches rows 2c and 2c+1 in
// the same cycle. One request (write or read) is taken every clock while
// the result side keeps up; a write completes at acceptance, a read's byte
// passes through the bank read register and then the result register.
// in_stall rises only when both the bank read stage and the result register
// hold reads and out_stall is high. The store is not cleared at reset:
// reading a byte that was never written returns an unspecified value.
// nibble_mode is sampled when a read is accepted; change it only when idle.
module subbyte_tile_transposer
    import stt_pkg::*;
#(
    parameter int TILE_ELEMS = STT_TILE_ELEMS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    // request channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               opcode,
    input  wire logic [5:0]         row_index,
    input  wire logic [5:0]         byte_column,
    input  wire logic [7:0]         write_byte,
    // result channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [7:0]         read_byte
);

    localparam int IDX_W      = $clog2(TILE_ELEMS);
    localparam int CMP_W      = (IDX_W + 1 > 7) ? IDX_W + 1 : 7;
    localparam int BANK_ROWS  = (TILE_ELEMS + 1) / 2;
    localparam int BANK_DEPTH = BANK_ROWS * TILE_ELEMS;
    localparam int ADDR_W     = $clog2(BANK_DEPTH);
    localparam int PROD_W     = 2 * CMP_W;

    logic              nibble_mode;
    logic              accept;
    logic              wr_ok;
    logic              rd_issue;
    logic [CMP_W-1:0]  row_ext;
    logic [CMP_W-1:0]  col_ext;
    logic [PROD_W-1:0] wr_lin;
    logic [PROD_W-1:0] rd8_lin;
    logic [PROD_W-1:0] rd4_lin;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        bank0_data;
    logic [7:0]        bank1_data;
    stt_rd_info_t      rd_info;
    stt_status_t       status;

    stt_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .nibble_mode (nibble_mode)
    );

    // Request handshake
    assign in_stall = status.hold;
    assign accept = in_valid && !in_stall;

    assign row_ext = CMP_W'(row_index);
    assign col_ext = CMP_W'(byte_column);

    // Write: original row r, byte column c -> bank r[0], row r/2
    assign wr_ok = accept && (opcode == OP_WRITE)
        && (row_ext < CMP_W'(TILE_ELEMS)) && (col_ext < CMP_W'(TILE_ELEMS));
    assign wr_lin = PROD_W'(row_ext >> 1) * PROD_W'(TILE_ELEMS) + PROD_W'(col_ext);
    assign wr_addr = wr_lin[ADDR_W-1:0];

    // int8 read: original row c, column r -> bank c[0], row c/2
    assign rd8_lin = PROD_W'(col_ext >> 1) * PROD_W'(TILE_ELEMS) + PROD_W'(row_ext);
    // int4 read: original rows 2c and 2c+1 -> row c of each bank, byte r/2
    assign rd4_lin = PROD_W'(col_ext) * PROD_W'(TILE_ELEMS) + PROD_W'(row_ext >> 1);
    assign rd_addr = nibble_mode ? rd4_lin[ADDR_W-1:0] : rd8_lin[ADDR_W-1:0];

    assign rd_issue = accept && (opcode == OP_READ);

    // Control carried to the result stage
    always_comb
    begin
        rd_info.nibble = nibble_mode;
        rd_info.bank_sel = byte_column[0];
        rd_info.odd_elem = row_index[0];
        if (nibble_mode)
        begin
            rd_info.in_range = (row_ext < CMP_W'(TILE_ELEMS))
                && (col_ext < CMP_W'(TILE_ELEMS / 2));
        end
        else
        begin
            rd_info.in_range = (row_ext < CMP_W'(TILE_ELEMS))
                && (col_ext < CMP_W'(TILE_ELEMS));
        end
    end

    // Even original rows
    stt_bank #(
        .DEPTH  (BANK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_bank0 (
        .clk     (clk),
        .wr_en   (wr_ok && !row_index[0]),
        .wr_addr (wr_addr),
        .wr_data (write_byte),
        .rd_en   (rd_issue),
        .rd_addr (rd_addr),
        .rd_data (bank0_data)
    );

    // Odd original rows
    stt_bank #(
        .DEPTH  (BANK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_bank1 (
        .clk     (clk),
        .wr_en   (wr_ok && row_index[0]),
        .wr_addr (wr_addr),
        .wr_data (write_byte),
        .rd_en   (rd_issue),
        .rd_addr (rd_addr),
        .rd_data (bank1_data)
    );

    stt_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_issue   (rd_issue),
        .info_in    (rd_info),
        .bank0_data (bank0_data),
        .bank1_data (bank1_data),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .read_byte  (read_byte),
        .status     (status)
    );

    // An accepted read always lands in the bank read stage
    `STT_ASSERT_NEXT(a_read_enters_s1, rd_issue, status.s1_valid)
    // Requests are held off only when both read stages are full and blocked
    `STT_ASSERT_NOW(a_stall_only_full, in_stall, status.s1_valid && out_valid && out_stall)
    // A new result comes only from an occupied read stage
    `STT_ASSERT_NOW(a_result_source, $rose(out_valid), $past(status.s1_valid))

endmodule

`default_nettype wire
